// ----- design/greedy_vertex_colouring_macros.svh -----
// Assertion macros for the greedy vertex colouring block.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef GREEDY_VERTEX_COLOURING_MACROS_SVH
`define GREEDY_VERTEX_COLOURING_MACROS_SVH

`ifndef SYNTHESIS
`define GVC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond) else $error(msg);
`define GVC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define GVC_ASSERT(lbl, cond, msg)
`define GVC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- design/gvc_pkg.sv -----
// Shared constants, types and the first-free colour encoder.
// No dependencies.
`default_nettype none

package gvc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VTX_W        = 7;
  localparam int COL_W        = 6;
  localparam int COL_N        = 1 << COL_W;
  localparam int MASK_W       = 64;
  localparam int OUT_VTX_W    = 6;
  localparam int CNT_W        = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  localparam logic [OUT_VTX_W-1:0] VTX_OVF = OUT_VTX_W'(63);

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [COL_W-1:0] first_free(input logic [COL_N-1:0] used);
    logic [COL_W-1:0] c;
    c = COL_W'(COL_N - 1);
    for (int k = COL_N - 1; k >= 0; k--) begin
      if (!used[k]) c = COL_W'(k);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/gvc_cell.sv -----
// One cell of the colour ring: a stored vertex colour and a neighbour flag.
// Uses gvc_pkg.
`default_nettype none

module gvc_cell (
  input  wire logic                     clk,
  input  wire gvc_pkg::cell_ctrl_t      ctrl,
  input  wire logic                     load_mask,
  input  wire logic                     wr_en,
  input  wire logic [gvc_pkg::COL_W-1:0] wr_colour,
  input  wire logic [gvc_pkg::COL_W-1:0] nb_colour,
  input  wire logic                     nb_mask,
  output logic      [gvc_pkg::COL_W-1:0] colour,
  output logic                          mask
);
  import gvc_pkg::*;

  logic [COL_W-1:0] colour_r, colour_nxt;
  logic             mask_r, mask_nxt;

  always_comb begin
    colour_nxt = colour_r;
    mask_nxt   = mask_r;
    if (wr_en) begin
      colour_nxt = wr_colour;
    end else if (ctrl.shift) begin
      colour_nxt = nb_colour;
    end
    if (ctrl.load) begin
      mask_nxt = load_mask;
    end else if (ctrl.shift) begin
      mask_nxt = nb_mask;
    end
  end

  always_ff @(posedge clk) begin
    colour_r <= colour_nxt;
    mask_r   <= mask_nxt;
  end

  assign colour = colour_r;
  assign mask   = mask_r;

endmodule

`default_nettype wire

// ----- design/gvc_ring.sv -----
// Ring of colour cells that rotates one place a cycle towards cell 0 while shift is set.
// Uses gvc_pkg and gvc_cell.
`default_nettype none

module gvc_ring (
  input  wire logic                            clk,
  input  wire gvc_pkg::cell_ctrl_t             ctrl,
  input  wire logic [gvc_pkg::MAX_VERTICES-1:0] load_mask,
  input  wire logic [gvc_pkg::MAX_VERTICES-1:0] wr_en,
  input  wire logic [gvc_pkg::COL_W-1:0]        wr_colour,
  output logic      [gvc_pkg::COL_W-1:0]        head_colour,
  output logic                                 head_mask
);
  import gvc_pkg::*;

  logic [COL_W-1:0] colour [MAX_VERTICES];
  logic             mask   [MAX_VERTICES];

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_VERTICES;
    gvc_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_mask (load_mask[i]),
      .wr_en     (wr_en[i]),
      .wr_colour (wr_colour),
      .nb_colour (colour[NB]),
      .nb_mask   (mask[NB]),
      .colour    (colour[i]),
      .mask      (mask[i])
    );
  end

  assign head_colour = colour[0];
  assign head_mask   = mask[0];

endmodule

`default_nettype wire

// ----- design/greedy_vertex_colouring.sv -----
// Top level: vertex numbering, sweep control, used-colour accumulator, output register.
// Uses gvc_pkg, gvc_ring and the assertion macro header.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  in_new_graph, in_neighbor_mask
//  out      output     out_valid/out_ready  out_vertex, out_color, out_overflow
//
// An item is loaded, the colour ring then makes a full turn past the accumulator,
// and the result is encoded and stored. An overflow item skips the turn of the
// ring. One item is in work at a time; in_ready is high when idle. The result
// waits in an output register; a stalled result holds the encode step until taken.
// Reset is synchronous, active low; colour cells have none.
`default_nettype none

`include "greedy_vertex_colouring_macros.svh"

module greedy_vertex_colouring (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_new_graph,
  input  wire logic [gvc_pkg::MASK_W-1:0]    in_neighbor_mask,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [gvc_pkg::OUT_VTX_W-1:0] out_vertex,
  output logic      [gvc_pkg::COL_W-1:0]     out_color,
  output logic                               out_overflow
);
  import gvc_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_VERTICES - 1);
  localparam logic [VTX_W-1:0] CAP      = VTX_W'(MAX_VERTICES);

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [VTX_W-1:0]     next_vertex_r, next_vertex_nxt;
  logic [VTX_W-1:0]     vtx_r, vtx_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [COL_N-1:0]     used_r, used_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_VTX_W-1:0] out_vertex_r, out_vertex_nxt;
  logic [COL_W-1:0]     out_color_r, out_color_nxt;
  logic                 out_overflow_r, out_overflow_nxt;

  logic                    in_fire;
  logic                    emit_fire;
  logic [VTX_W-1:0]        v;
  logic                    v_ovf;
  logic [COL_W-1:0]        colour_sel;
  cell_ctrl_t              ctrl;
  logic [MAX_VERTICES-1:0] load_mask;
  logic [MAX_VERTICES-1:0] wr_en;
  logic [COL_W-1:0]        head_colour;
  logic                    head_mask;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign emit_fire  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign v          = in_new_graph ? '0 : next_vertex_r;
  assign v_ovf      = (v >= CAP);
  assign colour_sel = first_free(used_r);

  assign ctrl.load  = in_fire;
  assign ctrl.shift = (state_r == S_SWEEP);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      load_mask[i] = in_neighbor_mask[i] && (VTX_W'(i) < v);
      wr_en[i]     = emit_fire && !ovf_r && (vtx_r == VTX_W'(i));
    end
  end

  gvc_ring u_ring (
    .clk         (clk),
    .ctrl        (ctrl),
    .load_mask   (load_mask),
    .wr_en       (wr_en),
    .wr_colour   (colour_sel),
    .head_colour (head_colour),
    .head_mask   (head_mask)
  );

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    next_vertex_nxt  = next_vertex_r;
    vtx_nxt          = vtx_r;
    ovf_nxt          = ovf_r;
    used_nxt         = used_r;
    out_valid_nxt    = out_valid_r;
    out_vertex_nxt   = out_vertex_r;
    out_color_nxt    = out_color_r;
    out_overflow_nxt = out_overflow_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          vtx_nxt  = v;
          ovf_nxt  = v_ovf;
          used_nxt = '0;
          cnt_nxt  = '0;
          if (v_ovf) begin
            next_vertex_nxt = CAP;
            state_nxt       = S_EMIT;
          end else begin
            next_vertex_nxt = v + VTX_W'(1);
            state_nxt       = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        if (head_mask) used_nxt = used_r | (COL_N'(1) << head_colour);
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_fire) begin
          out_valid_nxt    = 1'b1;
          out_overflow_nxt = ovf_r;
          out_vertex_nxt   = ovf_r ? VTX_OVF : vtx_r[OUT_VTX_W-1:0];
          out_color_nxt    = ovf_r ? '0 : colour_sel;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      next_vertex_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      next_vertex_r <= next_vertex_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vtx_r          <= vtx_nxt;
    ovf_r          <= ovf_nxt;
    used_r         <= used_nxt;
    out_vertex_r   <= out_vertex_nxt;
    out_color_r    <= out_color_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_vertex   = out_vertex_r;
  assign out_color    = out_color_r;
  assign out_overflow = out_overflow_r;

  `GVC_ASSERT_NEXT(a_accept_busy, in_fire, (state_r != S_IDLE), "accept left block idle")
  `GVC_ASSERT(a_vtx_cap, (next_vertex_r <= CAP), "vertex count beyond capacity")
  `GVC_ASSERT(a_ovf_fields, (out_valid_r && out_overflow_r |-> (out_vertex_r == VTX_OVF && out_color_r == '0)), "overflow result fields wrong")
  `GVC_ASSERT_NEXT(a_sweep_count, (state_r == S_SWEEP && cnt_r != CNT_LAST), (state_r == S_SWEEP && cnt_r == $past(cnt_r) + CNT_W'(1)), "sweep count skipped")

endmodule

`default_nettype wire
